[design/dbms_pkg.sv]
// package for the debounced button move sequencer
// holds widths, reset values, register indexes and shared types; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dbms_pkg;

	localparam int PENDING_LIMIT_DEF = 255;
	localparam int TIME_BITS_DEF     = 32;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_ADDR_W = 3;
	localparam int POS_W      = 32;
	localparam int COUNT_W    = 8;
	localparam int MOVES_W    = 4;

	localparam logic [15:0] DEBOUNCE_TIME_RST     = 16'd50;
	localparam logic [15:0] MOVE_PAUSE_RST        = 16'd500;
	localparam logic [23:0] MOVE_DISTANCE_RST     = 24'd153600;
	localparam logic [3:0]  MOVES_PER_REQUEST_RST = 4'd3;
	localparam logic [15:0] ARRIVE_TOLERANCE_RST  = 16'd10;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DEBOUNCE_TIME     = 3'd0,
		REG_MOVE_PAUSE        = 3'd1,
		REG_MOVE_DISTANCE     = 3'd2,
		REG_MOVES_PER_REQUEST = 3'd3,
		REG_ARRIVE_TOLERANCE  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]        debounce_time;
		logic [15:0]        move_pause;
		logic signed [23:0] move_distance;
		logic [MOVES_W-1:0] moves_per_request;
		logic [15:0]        arrive_tolerance;
	} cfg_t;

	typedef struct packed {
		logic               write_target;
		logic signed [31:0] target_value;
		logic               move_reached;
		logic               sequence_active;
		logic               request_queued;
		logic [COUNT_W-1:0] pending_count;
	} res_t;

endpackage

`default_nettype wire

[design/dbms_cfg.sv]
// configuration registers of the move sequencer
// depends on dbms_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbms_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [dbms_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [dbms_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output dbms_pkg::cfg_t                       cfg
);

	dbms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time     <= dbms_pkg::DEBOUNCE_TIME_RST;
			cfg_q.move_pause        <= dbms_pkg::MOVE_PAUSE_RST;
			cfg_q.move_distance     <= dbms_pkg::MOVE_DISTANCE_RST;
			cfg_q.moves_per_request <= dbms_pkg::MOVES_PER_REQUEST_RST;
			cfg_q.arrive_tolerance  <= dbms_pkg::ARRIVE_TOLERANCE_RST;
		end else if (cfg_wen) begin
			unique case (dbms_pkg::cfg_reg_t'(cfg_addr))
				dbms_pkg::REG_DEBOUNCE_TIME:     cfg_q.debounce_time <= cfg_wdata[15:0];
				dbms_pkg::REG_MOVE_PAUSE:        cfg_q.move_pause <= cfg_wdata[15:0];
				dbms_pkg::REG_MOVE_DISTANCE:     cfg_q.move_distance <= cfg_wdata[23:0];
				dbms_pkg::REG_MOVES_PER_REQUEST: cfg_q.moves_per_request <= cfg_wdata[3:0];
				dbms_pkg::REG_ARRIVE_TOLERANCE:  cfg_q.arrive_tolerance <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/dbms_deb.sv]
// button debouncer: flags every settled level change, both edges
// depends on dbms_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbms_deb #(
	parameter int TIME_BITS = dbms_pkg::TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 level,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic [15:0]          debounce_time,
	output logic                      queued
);

	logic                 stable_q;
	logic                 prev_q;
	logic [TIME_BITS-1:0] change_time_q;
	logic [TIME_BITS-1:0] change_time_n;
	logic [TIME_BITS-1:0] elapsed;

	always_comb begin
		change_time_n = (level != prev_q) ? now : change_time_q;
		elapsed       = now - change_time_n;
		queued        = (elapsed > TIME_BITS'(debounce_time)) && (level != stable_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b1;
			prev_q        <= 1'b1;
			change_time_q <= '0;
		end else if (step) begin
			prev_q        <= level;
			change_time_q <= change_time_n;
			if (queued) begin
				stable_q <= level;
			end
		end
	end

endmodule

`default_nettype wire

[design/dbms_seq.sv]
// request queue and move burst sequencer, one tick per step
// depends on dbms_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbms_seq #(
	parameter int PENDING_LIMIT = dbms_pkg::PENDING_LIMIT_DEF,
	parameter int TIME_BITS     = dbms_pkg::TIME_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    step,
	input  wire logic                    queued,
	input  wire logic [TIME_BITS-1:0]    now,
	input  wire logic signed [31:0]      actual,
	input  wire dbms_pkg::cfg_t          cfg,
	output dbms_pkg::res_t               res
);

	localparam int PW = $clog2(PENDING_LIMIT + 1);

	logic [PW-1:0]                    pend_q, pend_inc, pend_n;
	logic                             busy_q, busy_n;
	logic [dbms_pkg::MOVES_W-1:0]     md_q, md_n;
	logic                             ta_q, ta_n;
	logic [31:0]                      tgt_q, tgt_n;
	logic [TIME_BITS-1:0]             fin_q, fin_n;
	logic [TIME_BITS-1:0]             since_fin;
	logic [31:0]                      diff, mag, offset;
	logic                             wr, reached;

	always_comb begin
		pend_inc  = (queued && (pend_q < PW'(PENDING_LIMIT))) ? pend_q + PW'(1) : pend_q;
		pend_n    = pend_inc;
		busy_n    = busy_q;
		md_n      = md_q;
		ta_n      = ta_q;
		tgt_n     = tgt_q;
		fin_n     = fin_q;
		wr        = 1'b0;
		reached   = 1'b0;
		offset    = {{8{cfg.move_distance[23]}}, cfg.move_distance};
		since_fin = now - fin_q;
		diff      = actual - tgt_q;
		mag       = diff[31] ? (32'd0 - diff) : diff;

		if (!busy_q && (pend_inc != '0)) begin
			md_n   = '0;
			busy_n = 1'b1;
			ta_n   = 1'b0;
			pend_n = pend_inc - PW'(1);
		end

		if (busy_n) begin
			if (md_n < cfg.moves_per_request) begin
				if (!ta_n) begin
					if (since_fin >= TIME_BITS'(cfg.move_pause)) begin
						tgt_n = actual + offset;
						ta_n  = 1'b1;
						wr    = 1'b1;
					end
				end else if (mag < {16'd0, cfg.arrive_tolerance}) begin
					md_n    = md_n + dbms_pkg::MOVES_W'(1);
					ta_n    = 1'b0;
					fin_n   = now;
					reached = 1'b1;
				end
			end else begin
				busy_n = 1'b0;
			end
		end

		res.write_target    = wr;
		res.target_value    = wr ? tgt_n : 32'd0;
		res.move_reached    = reached;
		res.sequence_active = busy_n;
		res.request_queued  = queued;
		res.pending_count   = dbms_pkg::COUNT_W'(pend_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			busy_q <= 1'b0;
			md_q   <= '0;
			ta_q   <= 1'b0;
			tgt_q  <= '0;
			fin_q  <= '0;
		end else if (step) begin
			pend_q <= pend_n;
			busy_q <= busy_n;
			md_q   <= md_n;
			ta_q   <= ta_n;
			tgt_q  <= tgt_n;
			fin_q  <= fin_n;
		end
	end

endmodule

`default_nettype wire

[design/debounced_button_move_sequencer_unit.sv]
// top level of the debounced button move sequencer
// depends on dbms_pkg, dbms_cfg, dbms_deb and dbms_seq
`timescale 1ns / 1ps
`default_nettype none

// Takes one tick (button level, ms time, actual position) per beat and returns
// one result per tick. A tick is captured in an input register, its whole
// debounce and move-sequencing update is done combinationally, and the result is
// held in an output register: a new tick can be taken every cycle unless out_ready
// holds the output back. The output register and the input register each hold
// one beat, so one more tick is taken while a result waits, then in_ready drops.
// Configuration registers are written through cfg_wen/cfg_addr/cfg_wdata and
// should only change while no tick is in flight.

module debounced_button_move_sequencer_unit #(
	parameter int PENDING_LIMIT = dbms_pkg::PENDING_LIMIT_DEF,
	parameter int TIME_BITS     = dbms_pkg::TIME_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [dbms_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [dbms_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            button_level,
	input  wire logic [31:0]                     time_ms,
	input  wire logic signed [31:0]              actual_position,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 write_target,
	output logic signed [31:0]                   target_value,
	output logic                                 move_reached,
	output logic                                 sequence_active,
	output logic                                 request_queued,
	output logic [dbms_pkg::COUNT_W-1:0]         pending_count
);

	dbms_pkg::cfg_t       cfg;
	dbms_pkg::res_t       res, res_q;
	logic                 valid_s1;
	logic                 level_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic signed [31:0]   actual_s1;
	logic                 out_valid_q;
	logic                 advance;
	logic                 queued;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1  <= button_level;
			time_s1   <= time_ms[TIME_BITS-1:0];
			actual_s1 <= actual_position;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	dbms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dbms_deb #(
		.TIME_BITS (TIME_BITS)
	) u_deb (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.level         (level_s1),
		.now           (time_s1),
		.debounce_time (cfg.debounce_time),
		.queued        (queued)
	);

	dbms_seq #(
		.PENDING_LIMIT (PENDING_LIMIT),
		.TIME_BITS     (TIME_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.queued (queued),
		.now    (time_s1),
		.actual (actual_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid       = out_valid_q;
	assign write_target    = res_q.write_target;
	assign target_value    = res_q.target_value;
	assign move_reached    = res_q.move_reached;
	assign sequence_active = res_q.sequence_active;
	assign request_queued  = res_q.request_queued;
	assign pending_count   = res_q.pending_count;

`ifndef SYNTH
	a_issue_or_reach: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.write_target && res_q.move_reached))
		else $error("target issued and reached in the same tick");

	a_issue_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.write_target) |-> res_q.sequence_active)
		else $error("target issued outside a burst");

	a_reach_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.move_reached) |-> res_q.sequence_active)
		else $error("move reached outside a burst");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed tick did not reach the output register");
`endif

endmodule

`default_nettype wire
